### hw/rtl/sfd_pkg.sv
package sfd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 32;
  localparam int unsigned WordCount = 6;
  localparam int unsigned PosW      = 5;
  localparam int unsigned WordIdxW  = $clog2(WordCount);

  localparam logic [ByteW-1:0] HdrFirst  = 8'h48;
  localparam logic [ByteW-1:0] HdrSecond = 8'hAA;
  localparam logic [ByteW-1:0] TrailCr   = 8'd13;
  localparam logic [ByteW-1:0] TrailLf   = 8'd10;

  localparam logic [PosW-1:0] PosFirstWord = 5'd2;
  localparam logic [PosW-1:0] PosLastWord  = 5'd25;
  localparam logic [PosW-1:0] PosTrailCr   = 5'd26;
  localparam logic [PosW-1:0] PosTrailLf   = 5'd27;
  localparam logic [PosW-1:0] PosLast      = 5'd29;

  localparam logic StatusGood = 1'b0;
  localparam logic StatusBad  = 1'b1;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t [WordCount-1:0] words;
    logic                  status;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } push_t;

endpackage

### hw/rtl/sfd_byte_if.sv
interface sfd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [sfd_pkg::ByteW-1:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

### hw/rtl/sfd_frame_if.sv
interface sfd_frame_if;
  logic                      valid;
  logic                      ready;
  logic [sfd_pkg::WordW-1:0] axis_word_0;
  logic [sfd_pkg::WordW-1:0] axis_word_1;
  logic [sfd_pkg::WordW-1:0] axis_word_2;
  logic [sfd_pkg::WordW-1:0] axis_word_3;
  logic [sfd_pkg::WordW-1:0] axis_word_4;
  logic [sfd_pkg::WordW-1:0] axis_word_5;
  logic                      frame_status;

  modport source(output valid, output axis_word_0, output axis_word_1, output axis_word_2,
                 output axis_word_3, output axis_word_4, output axis_word_5,
                 output frame_status, input ready);
  modport sink(input valid, input axis_word_0, input axis_word_1, input axis_word_2,
               input axis_word_3, input axis_word_4, input axis_word_5,
               input frame_status, output ready);
endinterface

### hw/rtl/sfd_collector.sv
module sfd_collector (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [sfd_pkg::ByteW-1:0] rx_byte_i,
  output sfd_pkg::push_t            push_o
);
  import sfd_pkg::*;

  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhArmed   = 2'd1;
  localparam logic [1:0] PhCollect = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  word_t           words_q [WordCount];
  logic [ByteW-1:0] trail_first_q;
  logic            trail_good_q;

  logic [PosW-1:0]     rel;
  logic [WordIdxW-1:0] word_idx;
  logic [1:0]          lane;
  logic                in_range;
  logic                wr_word;
  logic                wr_cr;
  logic                wr_lf;
  logic                last;

  assign rel      = pos_q - PosFirstWord;
  assign word_idx = rel[4:2];
  assign lane     = rel[1:0];
  assign in_range = (pos_q >= PosFirstWord) && (pos_q <= PosLast);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    wr_word = 1'b0;
    wr_cr   = 1'b0;
    wr_lf   = 1'b0;
    last    = 1'b0;
    case (phase_q)
      PhArmed: begin
        if (rx_byte_i == HdrSecond) begin
          phase_d = PhCollect;
          pos_d   = PosFirstWord;
        end else if (rx_byte_i == HdrFirst) begin
          pos_d = 5'd1;
        end else begin
          phase_d = PhHunt;
          pos_d   = '0;
        end
      end
      PhCollect: begin
        if (!in_range) begin
          phase_d = PhHunt;
          pos_d   = '0;
        end else begin
          wr_word = (pos_q <= PosLastWord);
          wr_cr   = (pos_q == PosTrailCr);
          wr_lf   = (pos_q == PosTrailLf);
          if (pos_q == PosLast) begin
            last    = 1'b1;
            phase_d = PhHunt;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 5'd1;
          end
        end
      end
      default: begin
        if (rx_byte_i == HdrFirst) begin
          phase_d = PhArmed;
          pos_d   = 5'd1;
        end else begin
          phase_d = PhHunt;
          pos_d   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      pos_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && wr_word) begin
      case (lane)
        2'd0:    words_q[word_idx][7:0]   <= rx_byte_i;
        2'd1:    words_q[word_idx][15:8]  <= rx_byte_i;
        2'd2:    words_q[word_idx][23:16] <= rx_byte_i;
        default: words_q[word_idx][31:24] <= rx_byte_i;
      endcase
    end
    if (accept_i && wr_cr) begin
      trail_first_q <= rx_byte_i;
    end
    if (accept_i && wr_lf) begin
      trail_good_q <= (trail_first_q == TrailCr) && (rx_byte_i == TrailLf);
    end
  end

  always_comb begin
    push_o.valid = accept_i && last;
    for (int k = 0; k < WordCount; k++) begin
      push_o.frame.words[k] = words_q[k];
    end
    push_o.frame.status = trail_good_q ? StatusGood : StatusBad;
  end

endmodule

### hw/rtl/sfd_out_buf.sv
module sfd_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sfd_pkg::push_t push_i,
  output logic           space_o,
  sfd_frame_if.source    frame_o
);
  import sfd_pkg::*;

  logic   out_vld_q;
  logic   skid_vld_q;
  frame_t out_q;
  frame_t skid_q;
  logic   pop;

  assign pop     = out_vld_q && frame_o.ready;
  assign space_o = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else if (!push_i.valid) begin
        out_vld_q <= 1'b0;
      end
    end else if (push_i.valid) begin
      if (out_vld_q) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push_i.valid) begin
        out_q <= push_i.frame;
      end
    end else if (push_i.valid) begin
      if (out_vld_q) begin
        skid_q <= push_i.frame;
      end else begin
        out_q <= push_i.frame;
      end
    end
  end

  assign frame_o.valid        = out_vld_q;
  assign frame_o.axis_word_0  = out_q.words[0];
  assign frame_o.axis_word_1  = out_q.words[1];
  assign frame_o.axis_word_2  = out_q.words[2];
  assign frame_o.axis_word_3  = out_q.words[3];
  assign frame_o.axis_word_4  = out_q.words[4];
  assign frame_o.axis_word_5  = out_q.words[5];
  assign frame_o.frame_status = out_q.status;

endmodule

### hw/rtl/sensor_frame_deframer_top.sv
// Deframer for the six-axis force/torque sensor byte link.
// rx_i (sink) takes one received byte per item; frame_o (source) gives one
// item per complete 30-byte frame: six little-endian 32-bit words from frame
// bytes 2..25 and frame_status (0 = CR LF trailer, 1 = bad trailer).
// The header 0x48 0xAA is hunted for; a repeated 0x48 keeps the hunt armed.
// Throughput: one byte per cycle while rx_i.ready is high. A complete frame
// is registered into the frame_o output register, or into the skid entry
// while frame_o holds an untaken one. Bytes that complete no frame give no item.
// Stall: frame_o has an output register plus one skid entry, so rx_i keeps
// taking bytes while a frame waits; rx_i.ready drops only while two frames
// are pending, i.e. after the receiver has stalled for a whole frame time.
// Reset (rst_ni low, asynchronous): back to hunting for 0x48, both output
// entries empty. Word and trailer registers are not reset; each is written
// before any frame that uses it is emitted.
module sensor_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfd_byte_if.sink    rx_i,
  sfd_frame_if.source frame_o
);
  import sfd_pkg::*;

  push_t push;
  logic  space;
  logic  accept;

  assign rx_i.ready = space;
  assign accept     = rx_i.valid && space;

  sfd_collector u_collector (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .push_o    (push)
  );

  sfd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .frame_o (frame_o)
  );

endmodule

### sim/tb_sensor_frame_deframer_top.sv
module tb_sensor_frame_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int CycleLimit    = 200000;
  localparam int RandomBytes   = 584;
  localparam int HoldOffCycles = 200;
  localparam int HoldFrames    = 4;
  localparam int DrainCycles   = 8;
  localparam int NumRows       = 12;

  typedef enum logic [1:0] {PhHunt, PhArmed, PhCollect} hunt_phase_e;
  typedef enum logic [2:0] {FillZero, FillOnes, FillWalk, FillHdr, FillRand} fill_e;

  typedef struct packed {
    logic [ByteW-1:0] lead_a;
    logic [ByteW-1:0] lead_b;
    logic [1:0]       lead_len;
    logic             header;
    fill_e            fill;
    logic [ByteW-1:0] cr;
    logic [ByteW-1:0] lf;
    logic [ByteW-1:0] pad;
    logic             typed;
    word_t            word;
    logic             status;
  } dir_row_t;

  dir_row_t dir_rows [NumRows] = '{
    '{8'h00, 8'h00, 2'd0, 1'b1, FillZero, TrailCr, TrailLf, 8'h00, 1'b1, 32'h0000_0000, StatusGood},
    '{8'h00, 8'h00, 2'd0, 1'b1, FillOnes, TrailCr, TrailLf, 8'hFF, 1'b1, 32'hFFFF_FFFF, StatusGood},
    '{8'h00, 8'h00, 2'd0, 1'b1, FillOnes, 8'hFF, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, StatusBad},
    '{8'h00, 8'h00, 2'd0, 1'b1, FillZero, 8'h00, 8'h00, 8'h00, 1'b1, 32'h0000_0000, StatusBad},
    '{8'h00, 8'h00, 2'd0, 1'b1, FillWalk, TrailCr, 8'h0B, 8'h00, 1'b0, 32'h0, StatusBad},
    '{8'h00, 8'h00, 2'd0, 1'b1, FillWalk, TrailLf, TrailCr, 8'h00, 1'b0, 32'h0, StatusBad},
    '{8'h00, 8'h00, 2'd0, 1'b1, FillWalk, 8'h0C, TrailLf, 8'h55, 1'b0, 32'h0, StatusBad},
    '{HdrFirst, HdrFirst, 2'd2, 1'b1, FillRand, TrailCr, TrailLf, HdrFirst, 1'b0, 32'h0, StatusGood},
    '{HdrFirst, 8'h00, 2'd2, 1'b1, FillRand, TrailCr, TrailLf, HdrSecond, 1'b0, 32'h0, StatusGood},
    '{HdrSecond, HdrFirst, 2'd2, 1'b1, FillHdr, TrailCr, TrailLf, 8'h00, 1'b0, 32'h0, StatusGood},
    '{HdrFirst, 8'h55, 2'd2, 1'b0, FillZero, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0, StatusGood},
    '{8'h00, 8'h00, 2'd0, 1'b1, FillHdr, TrailCr, TrailLf, HdrFirst, 1'b1, 32'hAA48_AA48, StatusGood}
  };

  logic clk_i;
  logic rst_ni;

  sfd_byte_if  rx_if ();
  sfd_frame_if frame_if ();

  sensor_frame_deframer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_if),
    .frame_o (frame_if)
  );

  // predictor state
  hunt_phase_e      ph;
  logic [PosW-1:0]  pos;
  word_t            lanes [WordCount];
  logic [ByteW-1:0] trail_first;
  logic             trail_ok;

  frame_t expected_frames [$];
  bit     byte_typed;
  frame_t byte_want;
  int     sender_idle_pct;
  int     recv_idle_pct;
  bit     holdoff_req;
  int     holdoff_left;
  int     fail_count;
  int     cycle_count;
  int     sent_count;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output frame_t fr);
    int rel;
    fr = '0;
    case (ph)
      PhArmed: begin
        if (b == HdrSecond) begin
          ph  = PhCollect;
          pos = PosFirstWord;
        end else if (b == HdrFirst) begin
          pos = 5'd1;
        end else begin
          ph  = PhHunt;
          pos = '0;
        end
        return 1'b0;
      end
      PhCollect: begin
        if (pos < PosFirstWord || pos > PosLast) begin
          ph  = PhHunt;
          pos = '0;
          return 1'b0;
        end
        if (pos <= PosLastWord) begin
          rel = int'(pos - PosFirstWord);
          lanes[rel / 4][8 * (rel % 4) +: 8] = b;
        end else if (pos == PosTrailCr) begin
          trail_first = b;
        end else if (pos == PosTrailLf) begin
          trail_ok = (trail_first == TrailCr) && (b == TrailLf);
        end
        if (pos == PosLast) begin
          for (int k = 0; k < WordCount; k++) fr.words[k] = lanes[k];
          fr.status = trail_ok ? StatusGood : StatusBad;
          ph  = PhHunt;
          pos = '0;
          return 1'b1;
        end
        pos = pos + 1'b1;
        return 1'b0;
      end
      default: begin
        if (b == HdrFirst) begin
          ph  = PhArmed;
          pos = 5'd1;
        end else begin
          ph  = PhHunt;
          pos = '0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [ByteW-1:0] noise_byte();
    case ($urandom_range(4))
      0:       return HdrFirst;
      1:       return HdrSecond;
      2:       return TrailCr;
      3:       return TrailLf;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input bit typed, input frame_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      rx_if.valid = 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    byte_typed    = typed;
    byte_want     = want;
    do @(posedge clk_i); while (!rx_if.ready);
    sent_count++;
  endtask

  task automatic send_seq(input logic [ByteW-1:0] seq [$], input bit typed, input frame_t want);
    foreach (seq[i]) send_byte(seq[i], typed && (i == seq.size() - 1), want);
  endtask

  task automatic rx_release();
    @(negedge clk_i);
    rx_if.valid = 1'b0;
  endtask

  initial begin
    frame_if.ready = 1'b0;
    holdoff_left   = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_left = HoldOffCycles;
        holdoff_req  = 1'b0;
      end
      if (!rst_ni) begin
        frame_if.ready = 1'b0;
      end else if (holdoff_left > 0) begin
        frame_if.ready = 1'b0;
        holdoff_left--;
      end else begin
        frame_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_frames
    frame_t predicted;
    frame_t got;
    frame_t want;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        if (deframe_byte(rx_if.rx_byte, predicted))
          expected_frames.push_back(byte_typed ? byte_want : predicted);
      end
      if (frame_if.valid && frame_if.ready) begin
        got.words[0] = frame_if.axis_word_0;
        got.words[1] = frame_if.axis_word_1;
        got.words[2] = frame_if.axis_word_2;
        got.words[3] = frame_if.axis_word_3;
        got.words[4] = frame_if.axis_word_4;
        got.words[5] = frame_if.axis_word_5;
        got.status   = frame_if.frame_status;
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected frame, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          for (int k = 0; k < WordCount; k++) begin
            if (got.words[k] !== want.words[k]) begin
              $display("%0t: axis_word_%0d expected %h actual %h", $time, k,
                       want.words[k], got.words[k]);
              fail_count++;
            end
          end
          if (got.status !== want.status) begin
            $display("%0t: frame_status expected %b actual %b", $time, want.status, got.status);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_sensor_frame_deframer_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic [ByteW-1:0] seq [$];
    logic [ByteW-1:0] b;
    frame_t           want;
    int               kind;
    int               stage;
    int               base;
    int               hold_frames;
    bit               pressure_done;
    rx_if.valid     = 1'b0;
    rx_if.rx_byte   = '0;
    rst_ni          = 1'b0;
    byte_typed      = 1'b0;
    byte_want       = '0;
    holdoff_req     = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    sent_count      = 0;
    hold_frames     = 0;
    pressure_done   = 1'b0;
    sender_idle_pct = 8;
    recv_idle_pct   = 62;
    ph              = PhHunt;
    pos             = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[r]) begin
      seq.delete();
      if (dir_rows[r].lead_len > 0) seq.push_back(dir_rows[r].lead_a);
      if (dir_rows[r].lead_len > 1) seq.push_back(dir_rows[r].lead_b);
      if (dir_rows[r].header) begin
        seq.push_back(HdrFirst);
        seq.push_back(HdrSecond);
      end
      for (int i = 0; i < 4 * WordCount; i++) begin
        case (dir_rows[r].fill)
          FillZero: seq.push_back(8'h00);
          FillOnes: seq.push_back(8'hFF);
          FillWalk: seq.push_back(8'(8'h01 << (i % 8)));
          FillHdr:  seq.push_back((i % 2 == 0) ? HdrFirst : HdrSecond);
          default:  seq.push_back(8'($urandom));
        endcase
      end
      seq.push_back(dir_rows[r].cr);
      seq.push_back(dir_rows[r].lf);
      seq.push_back(dir_rows[r].pad);
      seq.push_back(dir_rows[r].pad);
      want.words  = {WordCount{dir_rows[r].word}};
      want.status = dir_rows[r].status;
      send_seq(seq, dir_rows[r].typed, want);
    end

    base = sent_count;
    while (sent_count - base < RandomBytes) begin
      stage = (sent_count - base) * 3 / RandomBytes;
      if (stage == 0) begin
        sender_idle_pct = 8;
        recv_idle_pct   = 62;
      end else if (stage == 1) begin
        sender_idle_pct = 62;
        recv_idle_pct   = 8;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        if (!pressure_done) begin
          pressure_done = 1'b1;
          holdoff_req   = 1'b1;
          hold_frames   = HoldFrames;
        end
      end

      kind = (hold_frames > 0) ? 0 : int'($urandom_range(99));
      seq.delete();
      if (kind < 70) begin
        repeat ($urandom_range(2)) seq.push_back(noise_byte());
        seq.push_back(HdrFirst);
        seq.push_back(HdrSecond);
        repeat (4 * WordCount)
          seq.push_back(($urandom_range(3) == 0) ? noise_byte() : 8'($urandom));
        case ($urandom_range(3))
          0, 1: begin
            seq.push_back(TrailCr);
            seq.push_back(TrailLf);
          end
          2: begin
            seq.push_back(TrailCr);
            seq.push_back(8'($urandom));
          end
          default: begin
            seq.push_back(8'($urandom));
            seq.push_back(TrailLf);
          end
        endcase
        seq.push_back(8'($urandom));
        seq.push_back(8'($urandom));
      end else if (kind < 85) begin
        repeat ($urandom_range(6, 1)) seq.push_back(noise_byte());
      end else begin
        seq.push_back(HdrFirst);
        do b = 8'($urandom); while (b == HdrSecond || b == HdrFirst);
        seq.push_back(b);
      end
      send_seq(seq, 1'b0, '0);

      if (hold_frames > 0) begin
        hold_frames--;
        if (hold_frames == 0) begin
          rx_release();
          while (expected_frames.size() != 0) @(posedge clk_i);
          repeat (DrainCycles) @(posedge clk_i);
        end
      end
    end

    rx_release();
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_sensor_frame_deframer_top OK");
    end else begin
      $display("tb_sensor_frame_deframer_top NOT OK");
    end
    $finish;
  end

endmodule
